/* sv/gtbl_pkg.sv */
package gtbl_pkg;

  localparam int MAX_LON    = 256;
  localparam int MAX_LAT    = 128;
  localparam int MAX_LAYERS = 4;
  localparam int LON_W      = $clog2(MAX_LON);
  localparam int LAT_W      = $clog2(MAX_LAT);
  localparam int LAYER_W    = $clog2(MAX_LAYERS);
  localparam int ADDR_W     = LON_W + LAT_W + LAYER_W;
  localparam int DEPTH      = MAX_LON * MAX_LAT * MAX_LAYERS;

  localparam int COORD_W = 26;
  localparam int STEP_W  = 25;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int NUM_W   = COORD_W + FRAC_W;
  localparam int QUO_W   = NUM_W + 1;
  localparam int IDX_W   = QUO_W - FRAC_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 26;

  localparam logic [CFG_IDX_W-1:0] REG_LON_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LON_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LON_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 3'd6;

  localparam logic [1:0] ACT_STORE    = 2'd0;
  localparam logic [1:0] ACT_POINT    = 2'd1;
  localparam logic [1:0] ACT_BILINEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_P0   = 3'd1;
  localparam logic [2:0] MS_P1   = 3'd2;
  localparam logic [2:0] MS_HI   = 3'd3;
  localparam logic [2:0] MS_P2   = 3'd4;
  localparam logic [2:0] MS_FIN  = 3'd5;

  typedef struct packed {
    logic       clr;
    logic       ld_in;
    logic       div_start;
    logic       ld_idx;
    logic       mem_wr;
    logic       rd_en;
    logic [1:0] rd_corner;
    logic       cap_en;
    logic [1:0] cap_corner;
    logic [2:0] mstep;
    logic       ld_out;
  } gtbl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_store;
  } gtbl_stat_t;

endpackage

/* sv/gtbl_div.sv */
module gtbl_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [gtbl_pkg::DIFF_W-1:0] diff,
  input  logic [gtbl_pkg::STEP_W-1:0]     step,
  output logic                            done,
  output logic signed [gtbl_pkg::QUO_W-1:0]  quo
);
  import gtbl_pkg::*;

  logic [NUM_W-1:0]  n_r, n_nxt;
  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] s_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r, neg_r;
  logic [STEP_W:0]   trial;
  logic [DIFF_W-1:0] mag;
  logic [QUO_W-1:0]  qpos;

  assign mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign trial = {rem_r, n_r[NUM_W-1]};

  always_comb begin
    if (trial >= {1'b0, s_r}) begin
      rem_nxt = STEP_W'(trial - {1'b0, s_r});
      n_nxt   = {n_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[STEP_W-1:0];
      n_nxt   = {n_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {mag[COORD_W-1:0], {FRAC_W{1'b0}}};
      rem_r <= '0;
      s_r   <= (step == '0) ? STEP_W'(1) : step;
      neg_r <= diff[DIFF_W-1];
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  // floor for negative numerators: step down when a remainder is left
  assign qpos = {1'b0, n_r} + QUO_W'(neg_r && (rem_r != '0));
  assign quo  = neg_r ? $signed(~qpos + 1'b1) : $signed(qpos);
  assign done = done_r;

endmodule

/* sv/gtbl_datapath.sv */
module gtbl_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gtbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtbl_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [1:0]                        action,
  input  logic signed [gtbl_pkg::COORD_W-1:0] lon,
  input  logic signed [gtbl_pkg::COORD_W-1:0] lat,
  input  logic [1:0]                        layer,
  input  logic signed [gtbl_pkg::VAL_W-1:0] store_value,
  input  gtbl_pkg::gtbl_cmd_t               cmd,
  output gtbl_pkg::gtbl_stat_t              stat,
  output logic signed [gtbl_pkg::VAL_W-1:0] result_value,
  output logic [1:0]                        status,
  output logic                              fell_back
);
  import gtbl_pkg::*;

  logic signed [COORD_W-1:0] lon_origin_r, lat_origin_r;
  logic [STEP_W-1:0]         lon_step_r, lat_step_r;
  logic [8:0]                lon_count_r;
  logic [7:0]                lat_count_r;
  logic [2:0]                layer_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_origin_r  <= '0;
      lat_origin_r  <= '0;
      lon_step_r    <= STEP_W'(32768);
      lat_step_r    <= STEP_W'(32768);
      lon_count_r   <= 9'd256;
      lat_count_r   <= 8'd128;
      layer_count_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LON_ORIGIN:  lon_origin_r  <= cfg_wdata;
        REG_LAT_ORIGIN:  lat_origin_r  <= cfg_wdata;
        REG_LON_STEP:    lon_step_r    <= cfg_wdata[STEP_W-1:0];
        REG_LAT_STEP:    lat_step_r    <= cfg_wdata[STEP_W-1:0];
        REG_LON_COUNT:   lon_count_r   <= cfg_wdata[8:0];
        REG_LAT_COUNT:   lat_count_r   <= cfg_wdata[7:0];
        REG_LAYER_COUNT: layer_count_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the grid dimensions
  logic [12:0] lon_lim, lat_lim, lay_lim;
  assign lon_lim = (lon_count_r > 9'(MAX_LON)) ? 13'(MAX_LON) : 13'(lon_count_r);
  assign lat_lim = (13'(lat_count_r) > 13'(MAX_LAT)) ? 13'(MAX_LAT) : 13'(lat_count_r);
  assign lay_lim = (13'(layer_count_r) > 13'(MAX_LAYERS)) ? 13'(MAX_LAYERS)
                                                          : 13'(layer_count_r);

  // latched item
  logic [1:0]                act_r;
  logic [1:0]                layer_r;
  logic signed [VAL_W-1:0]   sv_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act_r   <= action;
      layer_r <= layer;
      sv_r    <= store_value;
      dx_r    <= DIFF_W'(lon) - DIFF_W'(lon_origin_r);
      dy_r    <= DIFF_W'(lat) - DIFF_W'(lat_origin_r);
    end
  end

  logic                     xdone, ydone;
  logic signed [QUO_W-1:0]  qx, qy;

  gtbl_div u_divx (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .diff(dx_r), .step(lon_step_r), .done(xdone), .quo(qx)
  );
  gtbl_div u_divy (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .diff(dy_r), .step(lat_step_r), .done(ydone), .quo(qy)
  );

  // indices and range flags
  logic signed [IDX_W:0] ix_e, iy_e;
  logic                  ix_ok, iy_ok, ix1_ok, iy1_ok, lay_ok;
  assign ix_e   = {qx[QUO_W-1], qx[QUO_W-1:FRAC_W]};
  assign iy_e   = {qy[QUO_W-1], qy[QUO_W-1:FRAC_W]};
  assign ix_ok  = !ix_e[IDX_W] && (ix_e < $signed((IDX_W+1)'(lon_lim)));
  assign iy_ok  = !iy_e[IDX_W] && (iy_e < $signed((IDX_W+1)'(lat_lim)));
  assign ix1_ok = !ix_e[IDX_W] && (ix_e + 1 < $signed((IDX_W+1)'(lon_lim)));
  assign iy1_ok = !iy_e[IDX_W] && (iy_e + 1 < $signed((IDX_W+1)'(lat_lim)));
  assign lay_ok = 13'(layer_r) < lay_lim;

  logic [LON_W-1:0]  ix_r;
  logic [LAT_W-1:0]  iy_r;
  logic [FRAC_W-1:0] tx_r, ty_r;
  logic              pt_ok_r, bl_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_idx) begin
      ix_r    <= ix_e[LON_W-1:0];
      iy_r    <= iy_e[LAT_W-1:0];
      tx_r    <= qx[FRAC_W-1:0];
      ty_r    <= qy[FRAC_W-1:0];
      pt_ok_r <= ix_ok && iy_ok && lay_ok;
      bl_ok_r <= ix1_ok && iy1_ok && lay_ok;
    end
  end

  // grid memory: bit 32 is the filled mark
  logic [VAL_W:0]      mem [DEPTH];
  logic [VAL_W:0]      q_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [ADDR_W-1:0]   wa, ra;
  logic [VAL_W:0]      wd;
  logic                we;
  logic [LON_W-1:0]    rx;
  logic [LAT_W-1:0]    ry;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign we = cmd.clr || (cmd.mem_wr && pt_ok_r);
  assign wa = cmd.clr ? clr_cnt_r : {layer_r[LAYER_W-1:0], iy_r, ix_r};
  assign wd = cmd.clr ? '0 : {1'b1, sv_r};
  assign rx = ix_r + LON_W'(cmd.rd_corner[0]);
  assign ry = iy_r + LAT_W'(cmd.rd_corner[1]);
  assign ra = {layer_r[LAYER_W-1:0], ry, rx};

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) q_r <= mem[ra];
  end

  logic [VAL_W:0] c_r [4];
  always_ff @(posedge clk) begin
    if (cmd.cap_en) c_r[cmd.cap_corner] <= q_r;
  end

  // blend sequence
  logic signed [VAL_W:0]        da;
  logic signed [FRAC_W:0]       tm;
  logic signed [VAL_W+FRAC_W+1:0] prod_r;
  logic signed [VAL_W-1:0]      lo_r, hi_r, bl_r, base;
  logic signed [VAL_W+1:0]      sum;

  always_comb begin
    da   = '0;
    tm   = $signed({1'b0, tx_r});
    base = lo_r;
    unique case (cmd.mstep)
      MS_P0: da = $signed({c_r[1][VAL_W-1], c_r[1][VAL_W-1:0]})
                - $signed({c_r[0][VAL_W-1], c_r[0][VAL_W-1:0]});
      MS_P1: begin
        da   = $signed({c_r[3][VAL_W-1], c_r[3][VAL_W-1:0]})
             - $signed({c_r[2][VAL_W-1], c_r[2][VAL_W-1:0]});
        base = $signed(c_r[0][VAL_W-1:0]);
      end
      MS_HI: base = $signed(c_r[2][VAL_W-1:0]);
      MS_P2: begin
        da = $signed({hi_r[VAL_W-1], hi_r}) - $signed({lo_r[VAL_W-1], lo_r});
        tm = $signed({1'b0, ty_r});
      end
      default: ;
    endcase
    sum = (VAL_W+2)'(base) + (VAL_W+2)'(prod_r >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.mstep)
      MS_P0: prod_r <= da * tm;
      MS_P1: begin
        lo_r   <= sum[VAL_W-1:0];
        prod_r <= da * tm;
      end
      MS_HI: hi_r <= sum[VAL_W-1:0];
      MS_P2: prod_r <= da * tm;
      MS_FIN: bl_r <= sum[VAL_W-1:0];
      default: ;
    endcase
  end

  // result register
  logic all_filled;
  assign all_filled = c_r[0][VAL_W] && c_r[1][VAL_W] && c_r[2][VAL_W] && c_r[3][VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      fell_back <= 1'b0;
      if (act_r == ACT_STORE) begin
        result_value <= '0;
        status       <= pt_ok_r ? ST_OK : ST_RANGE;
      end else if (act_r == ACT_BILINEAR && bl_ok_r && all_filled) begin
        result_value <= bl_r;
        status       <= ST_OK;
      end else begin
        fell_back <= (act_r == ACT_BILINEAR);
        if (!pt_ok_r) begin
          result_value <= '0;
          status       <= ST_RANGE;
        end else if (!c_r[0][VAL_W]) begin
          result_value <= '0;
          status       <= ST_EMPTY;
        end else begin
          result_value <= $signed(c_r[0][VAL_W-1:0]);
          status       <= ST_OK;
        end
      end
    end
  end

  assign stat.clr_done = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.div_done = xdone && ydone;
  assign stat.is_store = (act_r == ACT_STORE);

endmodule

/* sv/gtbl_ctrl.sv */
module gtbl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  gtbl_pkg::gtbl_stat_t stat,
  output gtbl_pkg::gtbl_cmd_t  cmd
);
  import gtbl_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV0 = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_IDX  = 4'd4;
  localparam logic [3:0] S_ACT  = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_RDL  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign take       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    ov_nxt    = (ov_r && out_tready) ? 1'b0 : ov_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: if (stat.div_done) state_nxt = S_IDX;
      S_IDX: begin
        cmd.ld_idx = 1'b1;
        state_nxt  = S_ACT;
      end
      S_ACT: begin
        k_nxt = '0;
        if (stat.is_store) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = k_r[1:0];
        cmd.cap_en     = (k_r != '0);
        cmd.cap_corner = k_r[1:0] - 2'd1;
        k_nxt          = k_r + 3'd1;
        if (k_r == 3'd3) state_nxt = S_RDL;
      end
      S_RDL: begin
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = 2'd3;
        k_nxt          = 3'd1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        cmd.mstep = k_r;
        k_nxt     = k_r + 3'd1;
        if (k_r == MS_FIN) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          cmd.ld_out = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

/* sv/grid_table_bilinear_lookup_top.sv */
// layered lon/lat grid table with store, point lookup and bilinear lookup.
// input channel in_*: one transfer per item; in_tuser carries the action
// (0 store, 1 point lookup, 2 bilinear lookup), in_tdata the position,
// layer and store value. output channel out_*: exactly one result transfer
// per item, value in out_tdata, status and fallback flag in out_tuser.
// configuration: cfg_we writes register cfg_index with cfg_wdata; write
// only while no item is in flight.
// one item at a time: after the input transfer the item goes through a start
// step, the shift-subtract dividers that find index and fraction of both
// axes, an index step, four corner reads on the single read port of the grid
// memory, the three multiply-add blends and the result register; a store
// skips the corner reads and blends. the next item is taken as soon as the
// result register is loaded, even while that result still waits.
// after reset the grid memory is swept clear, one cell per cycle, through
// all 131072 cells; in_tready stays low during the sweep.
// when the receiver stalls, the result is held on out_* and a finished
// second item waits inside until the first result has been taken.
module grid_table_bilinear_lookup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // lon, lat, layer, store_value, zero pad
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value
  output logic [2:0]  out_tuser,  // status, fell_back
  input  logic        cfg_we,
  input  logic [gtbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gtbl_pkg::CFG_W-1:0]     cfg_wdata
);
  import gtbl_pkg::*;

  gtbl_cmd_t  cmd;
  gtbl_stat_t stat;
  logic signed [VAL_W-1:0] result_value;
  logic [1:0] status;
  logic       fell_back;

  gtbl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .stat(stat), .cmd(cmd)
  );

  gtbl_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .action(in_tuser),
    .lon(in_tdata[25:0]),
    .lat(in_tdata[51:26]),
    .layer(in_tdata[53:52]),
    .store_value(in_tdata[85:54]),
    .cmd(cmd), .stat(stat),
    .result_value(result_value), .status(status), .fell_back(fell_back)
  );

  assign out_tdata = result_value;
  assign out_tuser = {fell_back, status};

endmodule
